>>> rtl/sepconv_pkg.sv
// Shared types and constants for the separable 3x3 convolution block.
package sepconv_pkg;

   // Frame geometry
   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int FW_W         = 11;
   localparam int FH_W         = 13;
   localparam int ROW_W        = 13;

   // Data widths
   localparam int PIX_W  = 8;
   localparam int TAP_W  = 16;
   localparam int PV_W   = PIX_W + 1 + TAP_W;   // unsigned pixel times signed tap
   localparam int VW_W   = 28;                  // vertical pass value
   localparam int PH_W   = VW_W + TAP_W;        // vertical value times tap
   localparam int OUT_W  = 48;

   // Configuration port
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_TAP_0   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_TAP_1   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_TAP_2   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_TAP_0  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_TAP_1  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_TAP_2  = CSR_IDX_W'(7);

   localparam logic [FW_W-1:0]  WIDTH_RESET  = FW_W'(640);
   localparam logic [FH_W-1:0]  HEIGHT_RESET = FH_W'(480);
   localparam logic [TAP_W-1:0] TAP_RESET    = TAP_W'(4096);

   // Controller to datapath commands
   typedef struct packed {
      logic             mem_en;    // working word accepted: read both line banks
      logic             mem_we;    // write pixel into current row bank
      logic             mem_bank;  // parity of current row
      logic [COL_W-1:0] mem_col;
      logic             vmul;      // vertical products
      logic             vadd;      // vertical sum, window shift
      logic             hmul;      // horizontal products
      logic             hadd;      // horizontal sum, finish item
      logic             above2_ok; // row two up lies inside the frame
      logic             above1_ok; // row one up lies inside the frame
      logic             col_zero;  // first column of a row
      logic             left_ok;   // left neighbor present
      logic             has_out;   // item produces a result word
      logic             frame_end; // last result of the frame
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free; // output register can take a word this cycle
   } dp_sts_type;

endpackage

>>> rtl/sepconv_ctrl.sv
// Controller: geometry registers, stream position and item sequencing.
module sepconv_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_mode,
   input  logic                           csr_we,
   input  logic [sepconv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sepconv_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  sepconv_pkg::dp_sts_type        sts,
   output sepconv_pkg::dp_cmd_type        cmd
);
   import sepconv_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_VMUL = 3'd1;
   localparam logic [2:0] ST_VADD = 3'd2;
   localparam logic [2:0] ST_HMUL = 3'd3;
   localparam logic [2:0] ST_HADD = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [FW_W-1:0]  width_ff;
   logic [FH_W-1:0]  height_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             above2_ok_ff, above1_ok_ff, col_zero_ff, left_ok_ff;
   logic             has_out_ff, frame_end_ff;

   logic [FW_W-1:0]  eff_w;
   logic [FH_W-1:0]  eff_h;
   logic [FW_W-1:0]  col_nx;
   logic             tail, accept, work, last_slot, geo_wr, finish;

   // Clamp geometry to the supported range
   always_comb begin
      if (width_ff == '0)
         eff_w = FW_W'(1);
      else if (width_ff > FW_W'(MAX_WIDTH))
         eff_w = FW_W'(MAX_WIDTH);
      else
         eff_w = width_ff;
      if (height_ff == '0)
         eff_h = FH_W'(1);
      else if (height_ff > FH_W'(HEIGHT_LIMIT))
         eff_h = FH_W'(HEIGHT_LIMIT);
      else
         eff_h = height_ff;
   end

   // Slot classification
   assign tail       = row_ff >= ROW_W'(eff_h);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign work       = accept && !(req_mode && !tail);
   assign last_slot  = (row_ff == ROW_W'(eff_h) + ROW_W'(1)) && (col_ff == '0);
   assign col_nx     = FW_W'(col_ff) + FW_W'(1);
   assign geo_wr     = csr_we && (csr_index == CSR_FRAME_WIDTH ||
                                  csr_index == CSR_FRAME_HEIGHT);
   assign finish     = (state_ff == ST_HADD) && (!has_out_ff || sts.out_free);

   // Advance the stream position; wrap after the last tail slot, restart on a geometry write
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (geo_wr) begin
         row_in = '0;
         col_in = '0;
      end else if (work) begin
         if (last_slot) begin
            row_in = '0;
            col_in = '0;
         end else if (col_nx >= eff_w) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_nx[COL_W-1:0];
         end
      end
   end

   // Step through the item sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (work) state_in = ST_VMUL;
         ST_VMUL: state_in = ST_VADD;
         ST_VADD: state_in = ST_HMUL;
         ST_HMUL: state_in = ST_HADD;
         ST_HADD: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         if (csr_we && csr_index == CSR_FRAME_WIDTH)
            width_ff <= csr_wdata[FW_W-1:0];
         if (csr_we && csr_index == CSR_FRAME_HEIGHT)
            height_ff <= csr_wdata[FH_W-1:0];
      end
   end

   // Latch per-item flags at acceptance
   always_ff @(posedge clock) begin
      if (work) begin
         above2_ok_ff <= row_ff >= ROW_W'(2);
         above1_ok_ff <= (row_ff != '0) && (row_ff <= ROW_W'(eff_h));
         col_zero_ff  <= col_ff == '0;
         left_ok_ff   <= (col_ff == '0) ? (eff_w >= FW_W'(2)) : (col_ff >= COL_W'(2));
         has_out_ff   <= (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
         frame_end_ff <= last_slot;
      end
   end

   // Drive datapath commands
   always_comb begin
      cmd.mem_en    = work;
      cmd.mem_we    = work && !tail;
      cmd.mem_bank  = row_ff[0];
      cmd.mem_col   = col_ff;
      cmd.vmul      = state_ff == ST_VMUL;
      cmd.vadd      = state_ff == ST_VADD;
      cmd.hmul      = state_ff == ST_HMUL;
      cmd.hadd      = finish;
      cmd.above2_ok = above2_ok_ff;
      cmd.above1_ok = above1_ok_ff;
      cmd.col_zero  = col_zero_ff;
      cmd.left_ok   = left_ok_ff;
      cmd.has_out   = has_out_ff;
      cmd.frame_end = frame_end_ff;
   end

endmodule

>>> rtl/sepconv_dp.sv
// Datapath: line banks, tap registers, vertical and horizontal passes, output word.
module sepconv_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sepconv_pkg::PIX_W-1:0]  req_pixel,
   input  logic                           csr_we,
   input  logic [sepconv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sepconv_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  sepconv_pkg::dp_cmd_type        cmd,
   output sepconv_pkg::dp_sts_type        sts,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sepconv_pkg::OUT_W-1:0]  rsp_filtered,
   output logic                           rsp_frame_end
);
   import sepconv_pkg::*;

   logic [PIX_W-1:0] bank0_mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] bank1_mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] rd0_ff, rd1_ff, pix_ff;
   logic             bank_ff;

   logic signed [TAP_W-1:0] vt0_ff, vt1_ff, vt2_ff, ht0_ff, ht1_ff, ht2_ff;
   logic signed [PV_W-1:0]  pv0_ff, pv1_ff, pv2_ff;
   logic signed [VW_W-1:0]  win1_ff, win2_ff, vnew;
   logic signed [VW_W-1:0]  left_ff, center_ff, right_ff;
   logic signed [PH_W-1:0]  ph0_ff, ph1_ff, ph2_ff;
   logic signed [OUT_W-1:0] ysum;
   logic signed [PIX_W:0]   above2_s, above1_s, pix_s;
   logic [OUT_W-1:0]        out_data_ff;
   logic                    out_last_ff, out_valid_ff, load;

   // Tap registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vt0_ff <= TAP_RESET;
         vt1_ff <= TAP_RESET;
         vt2_ff <= TAP_RESET;
         ht0_ff <= TAP_RESET;
         ht1_ff <= TAP_RESET;
         ht2_ff <= TAP_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_VERT_TAP_0)  vt0_ff <= csr_wdata[TAP_W-1:0];
         if (csr_index == CSR_VERT_TAP_1)  vt1_ff <= csr_wdata[TAP_W-1:0];
         if (csr_index == CSR_VERT_TAP_2)  vt2_ff <= csr_wdata[TAP_W-1:0];
         if (csr_index == CSR_HORIZ_TAP_0) ht0_ff <= csr_wdata[TAP_W-1:0];
         if (csr_index == CSR_HORIZ_TAP_1) ht1_ff <= csr_wdata[TAP_W-1:0];
         if (csr_index == CSR_HORIZ_TAP_2) ht2_ff <= csr_wdata[TAP_W-1:0];
      end
   end

   // Line banks: read old column value, then store the new pixel
   always_ff @(posedge clock) begin
      if (cmd.mem_en) begin
         rd0_ff <= bank0_mem_ff[cmd.mem_col];
         if (cmd.mem_we && !cmd.mem_bank)
            bank0_mem_ff[cmd.mem_col] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_en) begin
         rd1_ff <= bank1_mem_ff[cmd.mem_col];
         if (cmd.mem_we && cmd.mem_bank)
            bank1_mem_ff[cmd.mem_col] <= req_pixel;
      end
   end

   // Capture the pixel; tail slots feed zero
   always_ff @(posedge clock) begin
      if (cmd.mem_en) begin
         pix_ff  <= cmd.mem_we ? req_pixel : '0;
         bank_ff <= cmd.mem_bank;
      end
   end

   // Mask rows outside the frame
   always_comb begin
      above2_s = cmd.above2_ok ? $signed({1'b0, (bank_ff ? rd1_ff : rd0_ff)}) : '0;
      above1_s = cmd.above1_ok ? $signed({1'b0, (bank_ff ? rd0_ff : rd1_ff)}) : '0;
      pix_s    = $signed({1'b0, pix_ff});
   end

   // Vertical products
   always_ff @(posedge clock) begin
      if (cmd.vmul) begin
         pv2_ff <= PV_W'(above2_s) * PV_W'(vt2_ff);
         pv1_ff <= PV_W'(above1_s) * PV_W'(vt1_ff);
         pv0_ff <= PV_W'(pix_s) * PV_W'(vt0_ff);
      end
   end

   assign vnew = VW_W'(pv2_ff) + VW_W'(pv1_ff) + VW_W'(pv0_ff);

   // Shift the vertical window and pick the horizontal neighbors
   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff <= '0;
         win2_ff <= '0;
      end else if (cmd.vadd) begin
         win1_ff <= win2_ff;
         win2_ff <= vnew;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vadd) begin
         left_ff   <= cmd.left_ok ? win1_ff : '0;
         center_ff <= win2_ff;
         right_ff  <= cmd.col_zero ? '0 : vnew;
      end
   end

   // Horizontal products
   always_ff @(posedge clock) begin
      if (cmd.hmul) begin
         ph2_ff <= PH_W'(left_ff) * PH_W'(ht2_ff);
         ph1_ff <= PH_W'(center_ff) * PH_W'(ht1_ff);
         ph0_ff <= PH_W'(right_ff) * PH_W'(ht0_ff);
      end
   end

   assign ysum = OUT_W'(ph2_ff) + OUT_W'(ph1_ff) + OUT_W'(ph0_ff);
   assign load = cmd.hadd && cmd.has_out;

   // Output register: hold until the receiver takes the word
   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (load)
         out_valid_ff <= 1'b1;
      else if (rsp_tready)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= ysum;
         out_last_ff <= cmd.frame_end;
      end
   end

   assign sts.out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid     = out_valid_ff;
   assign rsp_filtered   = out_data_ff;
   assign rsp_frame_end  = out_last_ff;

endmodule

>>> rtl/separable_convolution_2d_top.sv
// Top level of the separable 3x3 convolution block.
// Usage:
//  req channel: one word per slot; tuser is the mode (0 pixel, 1 flush), tdata the
//  8-bit pixel. A frame takes width*height pixel words, then width+1 flush words
//  push out the tail. A flush word during the pixel part of a frame is taken and
//  dropped; a pixel word during the tail counts as a flush.
//  rsp channel: tdata is the 48-bit signed result with 24 fraction bits, tlast
//  marks the last result of a frame. Results leave in raster order, each one
//  produced by the input slot width+1 positions later.
//  csr port: write enable, index and data; written by the user only while the block is
//  idle, unchecked by the block. A width or height write restarts the frame position.
// Sequence: a working word occupies the sequencer for its steps (bank read at the accept,
//  vertical multiply, vertical sum, horizontal multiply, horizontal sum): req_tready is
//  low in the multiply and sum steps; the horizontal sum loads any result for output.
//  A dropped flush word does not enter the sequence, so such words can follow back to back.
// Stall: a finished result waits in the output register; the next word is still
//  accepted, and its final stage holds until the register is free.
// Reset: geometry 640x480, all taps 1.0, position and window cleared. The line banks
//  need no clearing: every unmasked read hits a column written earlier in the frame.
module separable_convolution_2d_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] pixel
   input  logic                              req_tuser,  // [0] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // [47:0] filtered
   output logic                              rsp_tlast,  // frame_end
   input  logic                              csr_we,
   input  logic [sepconv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sepconv_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import sepconv_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sepconv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sts        (sts),
      .cmd        (cmd)
   );

   sepconv_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_pixel     (req_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_filtered  (rsp_tdata),
      .rsp_frame_end (rsp_tlast)
   );

   // Never overwrite a result that the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.hadd && cmd.has_out) |-> sts.out_free)
      else $error("result loaded while output register busy");

   // Only one step of the sequence is active at a time
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mem_en, cmd.vmul, cmd.vadd, cmd.hmul, cmd.hadd}))
      else $error("more than one sequencer step active");

   // An accepted working word starts the vertical multiply next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_en |=> cmd.vmul)
      else $error("bank read not followed by vertical multiply");

   // The vertical sum is followed directly by the horizontal multiply
   a_chain: assert property (@(posedge clock) disable iff (reset)
      cmd.vadd |=> cmd.hmul)
      else $error("vertical sum not followed by horizontal multiply");

   // No new word is taken while an item is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.vmul || cmd.vadd || cmd.hmul) |-> !req_tready)
      else $error("input ready while an item is in flight");

endmodule
